/* sv/bsh_pkg.sv */
// ----------------------------------------------------------------------------
// bsh_pkg: shared types and constants for the Burning Ship escape-time engine
// Word formats, config register indexes, iteration sequencer states.
// ----------------------------------------------------------------------------
package bsh_pkg;

  localparam int unsigned COORD_BITS = 11;
  localparam int unsigned FRAC_BITS  = 26;
  localparam int unsigned Q_W        = 32;   // Q6.26 coordinate width
  localparam int unsigned Z_W        = 31;   // |z| component, never negative
  localparam int unsigned SQ_W       = 2 * Z_W;
  localparam int unsigned STEP_W     = 27;
  localparam int unsigned ITER_W     = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned ACC_W      = COORD_BITS + 29;

  localparam logic [Q_W-1:0]    X_ORIGIN_RST = 32'hEC00_0000;  // -5.0
  localparam logic [Q_W-1:0]    Y_ORIGIN_RST = 32'hF300_0000;  // -3.25
  localparam logic [STEP_W-1:0] STEP_RST     = 27'd447392;     // ~1/150
  localparam logic [ITER_W-1:0] MAX_ITER_RST = 7'd19;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN = 2'd0,
    CFG_Y_ORIGIN = 2'd1,
    CFG_STEP     = 2'd2,
    CFG_MAX_ITER = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } iter_state_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [ITER_W-1:0] iterations;
    logic              escaped;
  } out_word_t;

endpackage

/* sv/burning_ship_escape_time.sv */
// ----------------------------------------------------------------------------
// burning_ship_escape_time: Burning Ship escape-time engine
// Maps a pixel to c = origin + pixel*step and counts iterations to escape.
// ----------------------------------------------------------------------------
// One pixel word is in flight at a time. The pixel is mapped to the complex
// plane by a chain of COORD_BITS shift-add cells (one pixel bit per cell,
// both axes side by side), then saturated to Q6.26. The iteration unit runs
// each Burning Ship iteration as an ST_MUL step for the three products
// zr*zr, zi*zi, zr*zi, then an ST_UPD step for the |z|^2 >= 4 test and the
// update. The iteration count is at most min(max_iterations, MAX_ITER).
// in_stall_o stays high from accept until the result word is taken. Config
// registers are to be written by the user only while idle; the block
// itself does not enforce this.
module burning_ship_escape_time #(
  parameter int unsigned MAX_ITER = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bsh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bsh_pkg::Q_W-1:0]            cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bsh_pkg::in_word_t                  in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bsh_pkg::out_word_t                 out_word_o
);
  import bsh_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITER + 1);
  localparam int unsigned LIM_W = (CNT_W > ITER_W) ? CNT_W : ITER_W;

  // config registers
  logic [Q_W-1:0]    x_org_q, y_org_q;
  logic [STEP_W-1:0] step_q;
  logic [ITER_W-1:0] max_it_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_org_q  <= X_ORIGIN_RST;
      y_org_q  <= Y_ORIGIN_RST;
      step_q   <= STEP_RST;
      max_it_q <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_X_ORIGIN: x_org_q  <= cfg_data_i;
        CFG_Y_ORIGIN: y_org_q  <= cfg_data_i;
        CFG_STEP:     step_q   <= cfg_data_i[STEP_W-1:0];
        CFG_MAX_ITER: max_it_q <= cfg_data_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // limit clamped to MAX_ITER
  logic [LIM_W-1:0] limit;
  assign limit = (LIM_W'(max_it_q) > LIM_W'(MAX_ITER)) ? LIM_W'(MAX_ITER)
                                                       : LIM_W'(max_it_q);

  // busy from accept to result handoff
  logic in_acc, out_acc, busy_q;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
    end else if (out_acc) begin
      busy_q <= 1'b0;
    end
  end
  assign in_stall_o = busy_q;

  // mapping chain: stage 0 is the accepted word with origins as seed
  logic                    ch_valid [COORD_BITS+1];
  logic [COORD_BITS-1:0]   ch_px    [COORD_BITS+1];
  logic [COORD_BITS-1:0]   ch_py    [COORD_BITS+1];
  logic signed [ACC_W-1:0] ch_accx  [COORD_BITS+1];
  logic signed [ACC_W-1:0] ch_accy  [COORD_BITS+1];

  assign ch_valid[0] = in_acc;
  assign ch_px[0]    = in_word_i.pixel_x;
  assign ch_py[0]    = in_word_i.pixel_y;
  assign ch_accx[0]  = ACC_W'($signed(x_org_q));
  assign ch_accy[0]  = ACC_W'($signed(y_org_q));

  for (genvar k = 0; k < COORD_BITS; k++) begin : g_cell
    bsh_map_cell #(.BIT_POS(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (step_q),
      .valid_i (ch_valid[k]),
      .px_i    (ch_px[k]),
      .py_i    (ch_py[k]),
      .accx_i  (ch_accx[k]),
      .accy_i  (ch_accy[k]),
      .valid_o (ch_valid[k+1]),
      .px_o    (ch_px[k+1]),
      .py_o    (ch_py[k+1]),
      .accx_o  (ch_accx[k+1]),
      .accy_o  (ch_accy[k+1])
    );
  end

  // saturate to signed Q6.26
  localparam logic signed [ACC_W-1:0] QMAX = ACC_W'(33'sh0_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] QMIN = ACC_W'(-33'sh0_8000_0000);

  logic signed [ACC_W-1:0] ax, ay;
  logic signed [Q_W-1:0]   cr, ci;
  assign ax = ch_accx[COORD_BITS];
  assign ay = ch_accy[COORD_BITS];
  assign cr = (ax > QMAX) ? Q_W'(QMAX) : (ax < QMIN) ? Q_W'(QMIN) : Q_W'(ax);
  assign ci = (ay > QMAX) ? Q_W'(QMAX) : (ay < QMIN) ? Q_W'(QMIN) : Q_W'(ay);

  bsh_iter #(.LIM_W(LIM_W)) u_iter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (ch_valid[COORD_BITS]),
    .cr_i        (cr),
    .ci_i        (ci),
    .limit_i     (limit),
    .out_stall_i (out_stall_i),
    .done_o      (out_valid_o),
    .word_o      (out_word_o)
  );

  // checks
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_q) else $error("result word with no pixel in flight");

  a_acc_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o) else $error("input not held off after accept");

  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.escaped) |-> (out_word_o.iterations == ITER_W'(limit)))
    else $error("non-escaped count differs from limit");

  a_esc_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (LIM_W'(out_word_o.iterations) <= limit))
    else $error("count above limit");

endmodule

/* sv/bsh_map_cell.sv */
// ----------------------------------------------------------------------------
// bsh_map_cell: one bit slice of the pixel-to-plane mapping chain
// Adds step << BIT_POS to each running sum whose pixel bit BIT_POS is set.
// ----------------------------------------------------------------------------
module bsh_map_cell #(
  parameter int unsigned BIT_POS = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [bsh_pkg::STEP_W-1:0]             step_i,
  input  logic                                   valid_i,
  input  logic [bsh_pkg::COORD_BITS-1:0]         px_i,
  input  logic [bsh_pkg::COORD_BITS-1:0]         py_i,
  input  logic signed [bsh_pkg::ACC_W-1:0]       accx_i,
  input  logic signed [bsh_pkg::ACC_W-1:0]       accy_i,
  output logic                                   valid_o,
  output logic [bsh_pkg::COORD_BITS-1:0]         px_o,
  output logic [bsh_pkg::COORD_BITS-1:0]         py_o,
  output logic signed [bsh_pkg::ACC_W-1:0]       accx_o,
  output logic signed [bsh_pkg::ACC_W-1:0]       accy_o
);
  import bsh_pkg::*;

  logic                    valid_q;
  logic [COORD_BITS-1:0]   px_q, py_q;
  logic signed [ACC_W-1:0] accx_q, accx_d, accy_q, accy_d;
  logic signed [ACC_W-1:0] part;

  assign part   = $signed(ACC_W'(step_i) << BIT_POS);
  assign accx_d = px_i[BIT_POS] ? accx_i + part : accx_i;
  assign accy_d = py_i[BIT_POS] ? accy_i + part : accy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_i;
    py_q   <= py_i;
    accx_q <= accx_d;
    accy_q <= accy_d;
  end

  assign valid_o = valid_q;
  assign px_o    = px_q;
  assign py_o    = py_q;
  assign accx_o  = accx_q;
  assign accy_o  = accy_q;

endmodule

/* sv/bsh_iter.sv */
// ----------------------------------------------------------------------------
// bsh_iter: Burning Ship iteration sequencer
// Each iteration: square/cross products in ST_MUL, then test and update in ST_UPD.
// ----------------------------------------------------------------------------
module bsh_iter #(
  parameter int unsigned LIM_W = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [bsh_pkg::Q_W-1:0] cr_i,
  input  logic signed [bsh_pkg::Q_W-1:0] ci_i,
  input  logic [LIM_W-1:0]              limit_i,
  input  logic                          out_stall_i,
  output logic                          done_o,
  output bsh_pkg::out_word_t            word_o
);
  import bsh_pkg::*;

  localparam int unsigned T_W = SQ_W + 4;

  iter_state_e state_q, state_d;

  logic signed [Q_W-1:0] cr_q, ci_q;
  logic [LIM_W-1:0]      lim_q, cnt_q, cnt_d;
  logic [Z_W-1:0]        zr_q, zr_d, zi_q, zi_d;
  logic [SQ_W-1:0]       sr_q, si_q, x_q;
  logic                  esc_q, esc_d;

  logic [SQ_W:0]         mag;
  logic                  over;
  logic signed [T_W-1:0] tr, ti;
  logic [T_W-1:0]        ar, ai;
  logic [T_W-FRAC_BITS-1:0] shr, shi;

  assign mag  = {1'b0, sr_q} + {1'b0, si_q};
  assign over = mag >= ((SQ_W+1)'(1) << 54);   // |z|^2 >= 4 in Q11.52

  assign tr = $signed({4'b0, sr_q}) - $signed({4'b0, si_q})
            + ($signed(T_W'(cr_q)) <<< FRAC_BITS);
  assign ti = $signed({3'b0, x_q, 1'b0}) + ($signed(T_W'(ci_q)) <<< FRAC_BITS);
  assign ar = tr[T_W-1] ? T_W'(-tr) : T_W'(tr);
  assign ai = ti[T_W-1] ? T_W'(-ti) : T_W'(ti);
  assign shr = ar[T_W-1:FRAC_BITS];
  assign shi = ai[T_W-1:FRAC_BITS];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_UPD;
      ST_UPD: begin
        if (over || cnt_q >= lim_q) state_d = ST_DONE;
        else                        state_d = ST_MUL;
      end
      ST_DONE: if (!out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    zr_d  = zr_q;
    zi_d  = zi_q;
    cnt_d = cnt_q;
    esc_d = esc_q;
    case (state_q)
      ST_IDLE: begin
        zr_d  = '0;
        zi_d  = '0;
        cnt_d = '0;
        esc_d = 1'b0;
      end
      ST_UPD: begin
        if (over) begin
          esc_d = 1'b1;
        end else if (cnt_q < lim_q) begin
          zr_d  = (shr > (T_W-FRAC_BITS)'(32'h7FFF_FFFF)) ? '1 : Z_W'(shr);
          zi_d  = (shi > (T_W-FRAC_BITS)'(32'h7FFF_FFFF)) ? '1 : Z_W'(shi);
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q  <= zr_d;
    zi_q  <= zi_d;
    cnt_q <= cnt_d;
    esc_q <= esc_d;
    if (state_q == ST_IDLE && start_i) begin
      cr_q  <= cr_i;
      ci_q  <= ci_i;
      lim_q <= limit_i;
    end
    if (state_q == ST_MUL) begin
      sr_q <= SQ_W'(zr_q * zr_q);
      si_q <= SQ_W'(zi_q * zi_q);
      x_q  <= SQ_W'(zr_q * zi_q);
    end
  end

  assign done_o            = (state_q == ST_DONE);
  assign word_o.iterations = ITER_W'(cnt_q);
  assign word_o.escaped    = esc_q;

endmodule

/* test/burning_ship_escape_time_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// burning_ship_escape_time_tb: self-checking bench for the escape-time engine
// Directed rows (corner coordinates, limits, saturation), then random pixels
// under random register settings and four idle patterns. All results are
// checked in order, against typed-in values on fixed rows, else an in-bench predictor.
// ----------------------------------------------------------------------------
module burning_ship_escape_time_tb;
  import bsh_pkg::*;

  localparam int unsigned MAX_ITER   = 64;
  localparam int          WDOG_LIMIT = 20000;  // well above one pixel's worst case plus the longest stall run
  localparam int          RAND_ITEMS = 1640;
  localparam longint      ONE_Q26    = 64'sd67108864;
  localparam longint      Q26_MAX    = 64'sh7FFF_FFFF;

  // plan rows: register write or pixel word
  typedef enum logic {ROW_CFG, ROW_PIX} row_kind_e;

  typedef struct {
    row_kind_e kind;
    cfg_idx_e  idx;
    logic [Q_W-1:0] data;
    in_word_t  pix;
    bit        fixed;     // expected result typed in below
    out_word_t res;
  } plan_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [Q_W-1:0] cfg_data_i = '0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  in_word_t       in_word_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  out_word_t      out_word_o;

  // predictor copy of the registers
  logic signed [Q_W-1:0] x_org = X_ORIGIN_RST;
  logic signed [Q_W-1:0] y_org = Y_ORIGIN_RST;
  logic [STEP_W-1:0]     step  = STEP_RST;
  logic [ITER_W-1:0]     limit = MAX_ITER_RST;

  out_word_t   escape_q[$];   // expected results still owed by the block
  plan_row_t   plan[$];
  int          errors   = 0;
  int          rx_pct   = 0;  // receiver stall probability, percent
  int          tx_pct   = 0;  // sender gap probability, percent
  int          idle_cnt = 0;
  int          n_words  = 0;
  int          n_results = 0;
  int          n_escaped = 0;

  burning_ship_escape_time #(.MAX_ITER(MAX_ITER)) uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH %s at %0t", what, $realtime);
    errors++;
  endtask

  // c = origin + pix*step, saturated to Q6.26
  function automatic longint map_axis(input logic signed [Q_W-1:0] org,
                                      input logic [COORD_BITS-1:0] pix);
    longint v;
    v = longint'(org) + longint'(pix) * longint'(step);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  // |t| in Q12.52 down to Q6.26, truncated, saturated positive
  function automatic longint unsigned fold_q26(input longint t);
    longint unsigned u;
    u = (t < 0) ? longint'(-t) : longint'(t);
    u = u >> FRAC_BITS;
    return (u > Q26_MAX) ? Q26_MAX : u;
  endfunction

  function automatic out_word_t escape_time(input in_word_t w);
    longint cr, ci, tr, ti;
    longint unsigned zr, zi, mag;
    int cap, cnt;
    out_word_t r;
    cr  = map_axis(x_org, w.pixel_x);
    ci  = map_axis(y_org, w.pixel_y);
    cap = (limit > MAX_ITER) ? MAX_ITER : limit;
    zr = 0; zi = 0; cnt = 0;
    r.escaped = 1'b0;
    while (1) begin
      mag = zr * zr + zi * zi;
      if (mag >= (64'd1 << 54)) begin
        r.escaped = 1'b1;
        break;
      end
      if (cnt >= cap) break;
      // zr, zi < 2^27 here
      tr = longint'(zr * zr) - longint'(zi * zi) + cr * ONE_Q26;
      ti = longint'(2 * zr * zi) + ci * ONE_Q26;
      zr = fold_q26(tr);
      zi = fold_q26(ti);
      cnt++;
    end
    r.iterations = cnt[ITER_W-1:0];
    return r;
  endfunction

  // drop valid and wait until the engine is idle again
  task automatic drain();
    in_valid_i <= 1'b0;
    while (escape_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [Q_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_X_ORIGIN: x_org = data;
      CFG_Y_ORIGIN: y_org = data;
      CFG_STEP:     step  = data[STEP_W-1:0];
      CFG_MAX_ITER: limit = data[ITER_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // called on a rising edge; returns on the edge that took the word
  task automatic send_pixel(input in_word_t w, input bit fixed, input out_word_t res);
    bit   ready;
    int   gap;
    if ($urandom_range(99) < tx_pct) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do begin
      @(negedge clk_i);
      ready = !in_stall_o;   // stall is stable between edges
      @(posedge clk_i);
    end while (!ready);
    escape_q.push_back(fixed ? res : escape_time(w));
    n_words++;
  endtask

  task automatic plan_cfg(input cfg_idx_e idx, input logic [Q_W-1:0] data);
    plan_row_t r;
    r.kind = ROW_CFG; r.idx = idx; r.data = data;
    r.pix = '0; r.fixed = 1'b0; r.res = '0;
    plan.push_back(r);
  endtask

  task automatic plan_pix(input int x, input int y, input bit fixed,
                          input int it, input bit esc);
    plan_row_t r;
    r.kind = ROW_PIX;
    r.idx = CFG_X_ORIGIN; r.data = '0;
    r.pix.pixel_x = COORD_BITS'(x); r.pix.pixel_y = COORD_BITS'(y);
    r.fixed = fixed;
    r.res.iterations = ITER_W'(it); r.res.escaped = esc;
    plan.push_back(r);
  endtask

  // random register set: mostly a sensible window, sometimes raw bits
  task automatic shuffle_regs();
    logic [Q_W-1:0] xo, yo;
    if ($urandom_range(3) == 0) begin
      write_reg(CFG_X_ORIGIN, $urandom());
      write_reg(CFG_Y_ORIGIN, $urandom());
      write_reg(CFG_STEP, $urandom());
      write_reg(CFG_MAX_ITER, $urandom());
    end else begin
      xo = 32'($urandom_range(0, 3 * 67108864)) - 32'd167772160;  // -2.5 .. 0.5
      yo = 32'($urandom_range(0, 3 * 67108864)) - 32'd134217728;  // -2.0 .. 1.0
      write_reg(CFG_X_ORIGIN, xo);
      write_reg(CFG_Y_ORIGIN, yo);
      write_reg(CFG_STEP, $urandom_range(1, 65536));
      write_reg(CFG_MAX_ITER, $urandom_range(1, 64));
    end
  endtask

  // result checker, receiver stall and watchdog
  always @(posedge clk_i) begin
    out_word_t want;
    if (out_valid_o && !out_stall_i) begin
      n_results++;
      if (out_word_o.escaped) n_escaped++;
      if (escape_q.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = escape_q.pop_front();
        if (out_word_o.iterations !== want.iterations)
          report_mismatch($sformatf("iterations got %0d want %0d",
                                    out_word_o.iterations, want.iterations));
        if (out_word_o.escaped !== want.escaped)
          report_mismatch($sformatf("escaped got %0b want %0b",
                                    out_word_o.escaped, want.escaped));
      end
    end
    out_stall_i <= ($urandom_range(99) < rx_pct);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WDOG_LIMIT) begin
      $display("watchdog: no word moved in %0d cycles", WDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    int        ph;
    in_word_t  w;
    out_word_t none;
    none = '0;

    // directed: defaults, corners, limit handling, saturation
    plan_pix(0, 0, 1, 1, 1);                 // default window: c = -5-3.25i escapes after the first iteration
    plan_pix(2047, 2047, 0, 0, 0);
    plan_pix(750, 487, 0, 0, 0);
    plan_cfg(CFG_X_ORIGIN, 32'h0000_0000);
    plan_cfg(CFG_Y_ORIGIN, 32'h0000_0000);
    plan_cfg(CFG_STEP, 32'h0);               // zero step: c sits at the origin
    plan_cfg(CFG_MAX_ITER, 32'd127);         // clamps to MAX_ITER
    plan_pix(2047, 0, 1, 64, 0);
    plan_pix(0, 2047, 1, 64, 0);
    plan_cfg(CFG_MAX_ITER, 32'd0);           // no iterations at all
    plan_pix(5, 5, 1, 0, 0);
    plan_cfg(CFG_MAX_ITER, 32'd1);
    plan_cfg(CFG_X_ORIGIN, 32'h7FFF_FFFF);   // escape on the only allowed pass
    plan_pix(0, 0, 1, 1, 1);
    plan_cfg(CFG_STEP, 32'h0400_0000);       // pixel term overflows, c saturates
    plan_pix(2047, 2047, 1, 1, 1);
    plan_cfg(CFG_MAX_ITER, 32'd64);
    plan_pix(2047, 1024, 1, 1, 1);
    plan_cfg(CFG_X_ORIGIN, 32'h8000_0000);   // most negative c, |z| saturates
    plan_cfg(CFG_Y_ORIGIN, 32'h8000_0000);
    plan_cfg(CFG_STEP, 32'h0);
    plan_pix(0, 0, 1, 1, 1);
    plan_cfg(CFG_X_ORIGIN, 32'h0);
    plan_cfg(CFG_Y_ORIGIN, 32'h0);
    plan_cfg(CFG_STEP, 32'h07FF_FFFF);
    plan_pix(1, 1, 0, 0, 0);
    plan_pix(1, 0, 0, 0, 0);
    plan_cfg(CFG_X_ORIGIN, X_ORIGIN_RST);
    plan_cfg(CFG_Y_ORIGIN, Y_ORIGIN_RST);
    plan_cfg(CFG_STEP, Q_W'(STEP_RST));
    plan_cfg(CFG_MAX_ITER, Q_W'(MAX_ITER_RST));
    plan_pix(300, 300, 0, 0, 0);
    plan_pix(1024, 0, 0, 0, 0);
    plan_pix(700, 450, 0, 0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pixel(plan[i].pix, plan[i].fixed, plan[i].res);
      end
    end

    // random: four idle patterns, new registers every ~100 words
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 57; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 57; end
        default: begin tx_pct = 10; rx_pct = 10; end
      endcase
      for (int n = 0; n < RAND_ITEMS / 4; n++) begin
        if (n % 100 == 0) begin
          drain();           // sender holds off until every result is back
          shuffle_regs();
        end
        w.pixel_x = COORD_BITS'($urandom_range(0, 2047));
        w.pixel_y = COORD_BITS'($urandom_range(0, 2047));
        send_pixel(w, 0, none);
      end
    end

    in_valid_i <= 1'b0;
    while (escape_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("covered %0d pixel words, %0d results (%0d escaped)",
             n_words, n_results, n_escaped);
    $display("register corners, limit 0/1/clamp, saturation, four idle patterns");
    if (errors == 0 && escape_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
